// ===== rtl/repeat_pulse_output_timer_unit_defines.svh =====
// assertion macros of the repeat pulse output timer rtl, used by rpot_core
`ifndef REPEAT_PULSE_OUTPUT_TIMER_UNIT_DEFINES_SVH
`define REPEAT_PULSE_OUTPUT_TIMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RPOT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RPOT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RPOT_ASSERT(name, prop, msg)
`define RPOT_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== rtl/rpot_pkg.sv =====
// types and constants of the repeat pulse output timer
`timescale 1ns / 1ps
package rpot_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  localparam logic [CountW-1:0] WRAP_MAX = CountW'(1000000);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DELAY  = 2'd1,
    PH_ACTIVE = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // run modes, code 3 behaves as delayed
  localparam logic [1:0] MODE_DELAYED   = 2'd0;
  localparam logic [1:0] MODE_IMMEDIATE = 2'd1;
  localparam logic [1:0] MODE_GATED     = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_RUN_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INVERT       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ON_DELAY     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_TIME  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_LIMIT = 3'd4;

  typedef struct packed {
    logic [1:0]       run_mode;
    logic             invert_output;
    logic [TimeW-1:0] on_delay_ms;
    logic [TimeW-1:0] active_time_ms;
    logic [TimeW-1:0] repeat_limit;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             turn_off;
    logic             turn_on;
  } item_t;

  typedef struct packed {
    logic              command_active;
    phase_e            phase;
    logic [CountW-1:0] edge_count;
    logic              edge_pulse;
    logic              reset_override;
    logic              off_seen;
    logic              on_seen;
    logic              output_level;
  } result_t;

endpackage

// ===== rtl/repeat_pulse_output_timer_unit.sv =====
// top level of the repeat pulse output timer: stream ports and pipeline registers
`timescale 1ns / 1ps
// Repeating on-delay / pulse timer for one digital output. Each input transfer is one
// scan tick (turn-on, turn-off, millisecond timestamp) and produces exactly one result
// transfer with the output level, edge information, phase and edge count. The block
// takes one tick per clock while the downstream side does not stall: a tick is captured
// in an input register, passes the phase and timer logic and lands in the result
// register, from which the result is offered. Both registers keep moving while the
// downstream side stalls only as long as a slot is free. Configuration writes take
// effect on the next edge; the user must make them only while no tick is in flight,
// and the block itself does not enforce this.
module repeat_pulse_output_timer_unit
  import rpot_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // turn_on, turn_off, now_ms[31:0], zero pad
  input  logic [39:0]        s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // output_level, on_seen, off_seen, reset_override, edge_pulse, edge_count[19:0],
  // phase[1:0], command_active, zero pad
  output logic [31:0]        m_axis_tdata_o
);

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_valid_q;
  result_t res;
  result_t out_res_q;
  logic    out_valid_q;
  logic    out_free, step;

  rpot_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q <= item_t'(s_axis_tdata_i[33:0]);
    end
  end

  rpot_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_res_q};

endmodule

// ===== rtl/rpot_cfg.sv =====
// configuration registers of the repeat pulse output timer
`timescale 1ns / 1ps
module rpot_cfg
  import rpot_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RUN_MODE:     cfg_q.run_mode       <= cfg_wdata_i[1:0];
        REG_INVERT:       cfg_q.invert_output  <= cfg_wdata_i[0];
        REG_ON_DELAY:     cfg_q.on_delay_ms    <= cfg_wdata_i;
        REG_ACTIVE_TIME:  cfg_q.active_time_ms <= cfg_wdata_i;
        REG_REPEAT_LIMIT: cfg_q.repeat_limit   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/rpot_core.sv =====
// phase machine, timers and edge counter, one scan tick per step
`timescale 1ns / 1ps
`include "repeat_pulse_output_timer_unit_defines.svh"
module rpot_core
  import rpot_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  phase_e            phase_q, phase_d;
  logic              cmd_q, cmd_d;
  logic [TimeW-1:0]  dstart_q, dstart_d;
  logic [TimeW-1:0]  astart_q, astart_d;
  logic [TimeW-1:0]  cycles_q, cycles_d;
  logic [CountW-1:0] rise_cnt_q, rise_cnt_d;
  logic              last_level_q, last_level_d;

  phase_e            ph1;
  logic              cmd1;
  logic [TimeW-1:0]  dstart1, astart1, cycles1, cycles_inc;
  logic [TimeW-1:0]  elapsed_d, elapsed_a;
  logic              start, gated_drop, mission, level, rise;

  always_comb begin
    // start request first, then gating, then the timers
    start   = ((phase_q == PH_IDLE) || (phase_q == PH_DONE)) && item_i.turn_on;
    ph1     = phase_q;
    cmd1    = cmd_q;
    dstart1 = dstart_q;
    astart1 = astart_q;
    cycles1 = cycles_q;
    if (start) begin
      cmd1    = 1'b1;
      cycles1 = '0;
      if (cfg_i.run_mode == MODE_IMMEDIATE) begin
        ph1     = PH_ACTIVE;
        astart1 = item_i.now_ms;
      end else begin
        ph1     = PH_DELAY;
        dstart1 = item_i.now_ms;
      end
    end

    gated_drop = (cfg_i.run_mode == MODE_GATED) && !item_i.turn_on &&
                 ((ph1 == PH_DELAY) || (ph1 == PH_ACTIVE));

    elapsed_d  = item_i.now_ms - dstart1;
    elapsed_a  = item_i.now_ms - astart1;
    cycles_inc = cycles1 + TimeW'(1);

    phase_d  = ph1;
    cmd_d    = cmd1;
    dstart_d = dstart1;
    astart_d = astart1;
    cycles_d = cycles1;
    mission  = 1'b0;
    if (ph1 == PH_DELAY) begin
      // a zero delay always passes the compare
      if (elapsed_d >= cfg_i.on_delay_ms) begin
        phase_d  = PH_ACTIVE;
        astart_d = item_i.now_ms;
        mission  = 1'b1;
      end
    end else if (ph1 == PH_ACTIVE) begin
      mission = 1'b1;
      if ((cfg_i.active_time_ms != '0) && (elapsed_a >= cfg_i.active_time_ms)) begin
        cycles_d = cycles_inc;
        mission  = 1'b0;
        if ((cfg_i.repeat_limit != '0) && (cycles_inc >= cfg_i.repeat_limit)) begin
          cmd_d   = 1'b0;
          phase_d = PH_DONE;
        end else begin
          phase_d  = PH_DELAY;
          dstart_d = item_i.now_ms;
        end
      end
    end

    level      = cfg_i.invert_output ^ mission;
    rise       = !last_level_q && level;
    rise_cnt_d = rise_cnt_q;
    if (rise) begin
      rise_cnt_d = (rise_cnt_q >= WRAP_MAX) ? '0 : rise_cnt_q + CountW'(1);
    end
    last_level_d = level;

    if (item_i.turn_off || gated_drop) begin
      phase_d      = PH_IDLE;
      cmd_d        = 1'b0;
      dstart_d     = '0;
      astart_d     = '0;
      cycles_d     = '0;
      level        = cfg_i.invert_output;
      rise         = 1'b0;
      last_level_d = cfg_i.invert_output;
      rise_cnt_d   = item_i.turn_off ? '0 : rise_cnt_q;
    end

    res_o.output_level   = level;
    res_o.on_seen        = item_i.turn_on;
    res_o.off_seen       = item_i.turn_off;
    res_o.reset_override = item_i.turn_on && item_i.turn_off;
    res_o.edge_pulse     = rise;
    res_o.edge_count     = rise_cnt_d;
    res_o.phase          = phase_d;
    res_o.command_active = cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      cmd_q        <= 1'b0;
      dstart_q     <= '0;
      astart_q     <= '0;
      cycles_q     <= '0;
      rise_cnt_q   <= '0;
      last_level_q <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      cmd_q        <= cmd_d;
      dstart_q     <= dstart_d;
      astart_q     <= astart_d;
      cycles_q     <= cycles_d;
      rise_cnt_q   <= rise_cnt_d;
      last_level_q <= last_level_d;
    end
  end

  `RPOT_ASSERT(a_cmd_matches_phase,
    cmd_q == ((phase_q == PH_DELAY) || (phase_q == PH_ACTIVE)),
    "command flag out of step with phase")
  `RPOT_ASSERT(a_count_in_range, rise_cnt_q <= WRAP_MAX, "edge count beyond wrap value")
  `RPOT_ASSERT_NEXT(a_off_clears, step_i && item_i.turn_off,
    (phase_q == PH_IDLE) && (rise_cnt_q == '0) && !cmd_q,
    "turn-off did not clear the block")
  `RPOT_ASSERT_NEXT(a_rise_counts, step_i && res_o.edge_pulse,
    last_level_q && (rise_cnt_q != $past(rise_cnt_q)),
    "rising edge not recorded")

endmodule

// ===== tb/timer_scan_checker.sv =====
// checker for the repeat pulse output timer: predicts each scan result and compares it
`timescale 1ns / 1ps
module timer_scan_checker
  import rpot_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  // turn_on, turn_off, now_ms[31:0], zero pad
  input  logic [39:0]        s_axis_tdata_i,
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  // output_level, on_seen, off_seen, reset_override, edge_pulse, edge_count[19:0],
  // phase[1:0], command_active, zero pad
  input  logic [31:0]        m_axis_tdata_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  cfg_t              cfg_q;
  phase_e            phase_q;
  logic              mission_q;
  logic              edge_q;
  logic [TimeW-1:0]  dly_start_q;
  logic [TimeW-1:0]  act_start_q;
  logic [TimeW-1:0]  cycles_q;
  logic [CountW-1:0] rises_q;
  logic              last_level_q;

  result_t     pending_scans[$];
  int unsigned fails = 0;

  function automatic void drop_mission(input logic clear_rises);
    mission_q   = 1'b0;
    edge_q      = 1'b0;
    dly_start_q = '0;
    act_start_q = '0;
    cycles_q    = '0;
    if (clear_rises) begin
      rises_q = '0;
    end
    phase_q = PH_IDLE;
  endfunction

  function automatic void reset_model();
    cfg_q = '0;
    drop_mission(1'b1);
    last_level_q = 1'b0;
  endfunction

  function automatic result_t snapshot(input logic lvl, input item_t it);
    result_t r;
    r.output_level   = lvl;
    r.on_seen        = it.turn_on;
    r.off_seen       = it.turn_off;
    r.reset_override = it.turn_on & it.turn_off;
    r.edge_pulse     = edge_q;
    r.edge_count     = rises_q;
    r.phase          = phase_q;
    r.command_active = mission_q;
    return r;
  endfunction

  function automatic result_t predict_scan(input item_t it);
    logic was_high;
    logic idle_lvl;
    logic running;
    logic lvl;
    logic rose;
    was_high = last_level_q;
    idle_lvl = cfg_q.invert_output;
    running  = 1'b0;

    // turn-off wins over everything and clears the edge count
    if (it.turn_off) begin
      drop_mission(1'b1);
      last_level_q = idle_lvl;
      return snapshot(idle_lvl, it);
    end

    edge_q = 1'b0;
    if ((phase_q == PH_IDLE || phase_q == PH_DONE) && it.turn_on) begin
      mission_q = 1'b1;
      cycles_q  = '0;
      if (cfg_q.run_mode == MODE_IMMEDIATE) begin
        phase_q     = PH_ACTIVE;
        act_start_q = it.now_ms;
      end else begin
        phase_q     = PH_DELAY;
        dly_start_q = it.now_ms;
      end
    end

    // gated mode: losing the on condition drops to idle, edge count kept
    if (cfg_q.run_mode == MODE_GATED && (phase_q == PH_DELAY || phase_q == PH_ACTIVE) &&
        !it.turn_on) begin
      drop_mission(1'b0);
      last_level_q = idle_lvl;
      return snapshot(idle_lvl, it);
    end

    if (phase_q == PH_DELAY) begin
      if (cfg_q.on_delay_ms == '0 || (it.now_ms - dly_start_q) >= cfg_q.on_delay_ms) begin
        phase_q     = PH_ACTIVE;
        act_start_q = it.now_ms;
        running     = 1'b1;
      end
    end else if (phase_q == PH_ACTIVE) begin
      running = 1'b1;
      if (cfg_q.active_time_ms != '0 &&
          (it.now_ms - act_start_q) >= cfg_q.active_time_ms) begin
        cycles_q = cycles_q + TimeW'(1);
        running  = 1'b0;
        if (cfg_q.repeat_limit != '0 && cycles_q >= cfg_q.repeat_limit) begin
          mission_q = 1'b0;
          phase_q   = PH_DONE;
        end else begin
          phase_q     = PH_DELAY;
          dly_start_q = it.now_ms;
        end
      end
    end

    lvl  = cfg_q.invert_output ? !running : running;
    rose = !was_high && lvl;
    if (rose) begin
      rises_q = (rises_q >= WRAP_MAX) ? '0 : rises_q + CountW'(1);
    end
    edge_q       = rose;
    last_level_q = lvl;
    return snapshot(lvl, it);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t got;
    if (!rst_ni) begin
      reset_model();
      pending_scans.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RUN_MODE:     cfg_q.run_mode       = cfg_wdata_i[1:0];
          REG_INVERT:       cfg_q.invert_output  = cfg_wdata_i[0];
          REG_ON_DELAY:     cfg_q.on_delay_ms    = cfg_wdata_i;
          REG_ACTIVE_TIME:  cfg_q.active_time_ms = cfg_wdata_i;
          REG_REPEAT_LIMIT: cfg_q.repeat_limit   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pending_scans.push_back(predict_scan(item_t'(s_axis_tdata_i[33:0])));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = result_t'(m_axis_tdata_i[27:0]);
        if (pending_scans.size() == 0) begin
          $error("result transfer %0h with no scan outstanding", m_axis_tdata_i);
          fails++;
        end else begin
          want = pending_scans.pop_front();
          check_field("output_level", 32'(want.output_level), 32'(got.output_level));
          check_field("on_seen", 32'(want.on_seen), 32'(got.on_seen));
          check_field("off_seen", 32'(want.off_seen), 32'(got.off_seen));
          check_field("reset_override", 32'(want.reset_override), 32'(got.reset_override));
          check_field("edge_pulse", 32'(want.edge_pulse), 32'(got.edge_pulse));
          check_field("edge_count", 32'(want.edge_count), 32'(got.edge_count));
          check_field("phase", 32'(want.phase), 32'(got.phase));
          check_field("command_active", 32'(want.command_active), 32'(got.command_active));
          check_field("pad", 32'd0, 32'(m_axis_tdata_i[31:28]));
        end
      end
    end
    pending_o    <= pending_scans.size();
    fail_count_o <= fails;
  end

endmodule

// ===== tb/repeat_pulse_output_timer_unit_tb.sv =====
// testbench top of the repeat pulse output timer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module repeat_pulse_output_timer_unit_tb;
  import rpot_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  logic               tx_valid;
  logic               s_axis_tready_o;
  // turn_on, turn_off, now_ms[31:0], zero pad
  logic [39:0]        tx_data;
  logic               m_axis_tvalid_o;
  logic               rx_ready;
  // output_level, on_seen, off_seen, reset_override, edge_pulse, edge_count[19:0],
  // phase[1:0], command_active, zero pad
  logic [31:0]        m_axis_tdata_o;

  int unsigned fail_count;
  int unsigned pending;

  // shared pacing flags
  bit          no_idle       = 1'b0;
  bit          long_hold_req = 1'b0;
  logic [31:0] now_ms;

  always #10 clk_i = ~clk_i;

  repeat_pulse_output_timer_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (tx_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (tx_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (rx_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  timer_scan_checker i_scan_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (tx_valid),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (tx_data),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (rx_ready),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  task automatic apply_config(input cfg_t c);
    logic [CfgW-1:0] vals[5];
    logic [CfgIdxW-1:0] idxs[5];
    vals[0] = CfgW'(c.run_mode);      idxs[0] = REG_RUN_MODE;
    vals[1] = CfgW'(c.invert_output); idxs[1] = REG_INVERT;
    vals[2] = c.on_delay_ms;          idxs[2] = REG_ON_DELAY;
    vals[3] = c.active_time_ms;       idxs[3] = REG_ACTIVE_TIME;
    vals[4] = c.repeat_limit;         idxs[4] = REG_REPEAT_LIMIT;
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_scan(input logic on, input logic off, input logic [31:0] t);
    int    gap;
    item_t it;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    it.turn_on  = on;
    it.turn_off = off;
    it.now_ms   = t;
    if (gap != 0) begin
      tx_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tx_valid <= 1'b1;
    tx_data  <= {6'd0, it};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // advance the millisecond clock and send one scan tick
  task automatic tick(input logic on, input logic off, input logic [31:0] dt);
    now_ms = now_ms + dt;
    send_scan(on, off, now_ms);
  endtask

  // sender pauses until every result is back, then waits for the pipeline to settle
  task automatic drain();
    tx_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver side: random stall per transfer, one long hold-off on request
  initial begin : result_sink
    int w;
    rx_ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        w = 300;
        long_hold_req = 1'b0;
      end else begin
        w = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (w != 0) begin
        rx_ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      rx_ready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && rx_ready));
    end
  end

  initial begin : timeout
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    cfg_t c;
    logic on_lvl;
    logic on_bit;
    logic off_bit;
    logic [31:0] step;
    int r;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    tx_valid  <= 1'b0;
    tx_data   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // delayed, inverted: first idle tick rises, timers cross the 32-bit wrap
    c = '{run_mode: MODE_DELAYED, invert_output: 1'b1, on_delay_ms: 32'd2,
          active_time_ms: 32'd2, repeat_limit: 32'd2};
    apply_config(c);
    now_ms = 32'hFFFF_FFFE;
    tick(0, 0, 0); tick(1, 0, 0); tick(1, 0, 1); tick(1, 0, 1);
    tick(1, 0, 1); tick(1, 0, 1); tick(1, 0, 1); tick(1, 0, 1);
    tick(1, 0, 2); tick(0, 0, 1); tick(1, 1, 0); tick(0, 1, 1);
    drain();

    // gated, zero times: immediate activity, stays active, drop on lost condition
    c = '{run_mode: MODE_GATED, invert_output: 1'b0, on_delay_ms: 32'd0,
          active_time_ms: 32'd0, repeat_limit: 32'd0};
    apply_config(c);
    tick(1, 0, 1); tick(1, 0, 5); tick(0, 0, 1); tick(1, 0, 1); tick(1, 1, 1);
    drain();

    // immediate, all registers at their maximum
    c = '{run_mode: MODE_IMMEDIATE, invert_output: 1'b0, on_delay_ms: 32'hFFFF_FFFF,
          active_time_ms: 32'hFFFF_FFFF, repeat_limit: 32'hFFFF_FFFF};
    apply_config(c);
    now_ms = 32'd0;
    tick(1, 0, 0); tick(1, 0, 32'hFFFF_FFFF); tick(0, 0, 1);
    drain();

    // unused mode code behaves as delayed
    c = '{run_mode: 2'd3, invert_output: 1'b1, on_delay_ms: 32'd1,
          active_time_ms: 32'd1, repeat_limit: 32'd1};
    apply_config(c);
    tick(1, 0, 0); tick(1, 0, 1); tick(1, 0, 1); tick(0, 0, 1);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      c.run_mode      = 2'($urandom_range(0, 3));
      c.invert_output = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 9);
      c.on_delay_ms    = (r == 0) ? $urandom() : 32'($urandom_range(0, 8));
      r = $urandom_range(0, 9);
      c.active_time_ms = (r == 0) ? $urandom() : 32'($urandom_range(0, 8));
      r = $urandom_range(0, 9);
      c.repeat_limit   = (r == 0) ? $urandom() : 32'($urandom_range(0, 4));
      apply_config(c);
      no_idle = ($urandom_range(0, 3) == 0);
      if (ph == 4) begin
        // sender keeps offering while the receiver holds off, so the block backs up
        no_idle       = 1'b1;
        long_hold_req = 1'b1;
      end
      now_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200)
                                           : $urandom();
      on_lvl = 1'b1;
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          on_lvl = ~on_lvl;
        end
        // mostly a held on condition, a little noise on top
        on_bit  = (r >= 94) ? 1'($urandom_range(0, 1)) : on_lvl;
        off_bit = ($urandom_range(0, 99) < 3);
        step    = (r >= 97) ? $urandom() : 32'($urandom_range(0, 4));
        now_ms  = now_ms + step;
        send_scan(on_bit, off_bit, now_ms);
      end
      drain();
      if (ph == 4) begin
        long_hold_req = 1'b0;
      end
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
